@@ src/pbd_pkg.sv @@
// Shared types and constants of the PackBits plane decoder.
package pbd_pkg;

  // Width of the pixel index counter inside the plane
  localparam int INDEX_BITS = 24;

  // Field widths of the stream words
  localparam int BYTE_BITS   = 8;
  localparam int CFG_BITS    = 24;
  localparam int START_BITS  = 24;
  localparam int LENGTH_BITS = 8;

  // Header byte that stands for no operation
  localparam logic [BYTE_BITS-1:0] HDR_NOP = 8'd128;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // One decoded run, as it travels through the queue
  typedef struct packed {
    logic                   plane_done;
    logic [LENGTH_BITS-1:0] run_length;
    logic [START_BITS-1:0]  run_start;
    logic [BYTE_BITS-1:0]   pixel_value;
  } pbd_run_t;

  // Plane size register write
  typedef struct packed {
    logic                valid;
    logic [CFG_BITS-1:0] data;
  } pbd_cfg_t;

endpackage

@@ src/pbd_front.sv @@
// Front end: header parsing, pixel accounting and run formation per byte.
module pbd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pbd_pkg::pbd_cfg_t                 cfg,
  input  logic                              byte_fire,
  input  logic [pbd_pkg::BYTE_BITS-1:0]     code_byte,
  output logic                              run_push,
  output pbd_pkg::pbd_run_t                 run_data
);
  import pbd_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_VALUE   = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;

  logic [CFG_BITS-1:0]    plane_pixels_r;
  logic [1:0]             phase_r, phase_nxt;
  logic [BYTE_BITS-1:0]   literal_left_r, literal_left_nxt;
  logic [LENGTH_BITS:0]   repeat_length_r, repeat_length_nxt;
  logic [INDEX_BITS-1:0]  pixel_index_r, pixel_index_nxt;

  logic [INDEX_BITS-1:0]  plane_size;
  logic [INDEX_BITS-1:0]  pixels_left;
  logic [LENGTH_BITS:0]   want;
  logic [LENGTH_BITS:0]   run_len;
  logic                   run_done;
  logic                   is_run;
  logic [BYTE_BITS-1:0]   literal_dec;

  // Clip the wanted length to the pixels left in the plane
  always_comb begin
    plane_size  = INDEX_BITS'(plane_pixels_r);
    pixels_left = (pixel_index_r < plane_size) ? plane_size - pixel_index_r
                                               : INDEX_BITS'(1);
    want        = (phase_r == PH_VALUE) ? repeat_length_r : (LENGTH_BITS + 1)'(1);
    if (INDEX_BITS'(want) < pixels_left) begin
      run_len = want;
    end else begin
      run_len = (LENGTH_BITS + 1)'(pixels_left);
    end
    run_done = (INDEX_BITS'(run_len) == pixels_left);
    is_run   = (phase_r == PH_VALUE) || (phase_r == PH_LITERAL);
  end

  // Advance the decode state for an accepted byte
  always_comb begin
    phase_nxt         = phase_r;
    literal_left_nxt  = literal_left_r;
    repeat_length_nxt = repeat_length_r;
    pixel_index_nxt   = pixel_index_r;
    literal_dec       = literal_left_r - BYTE_BITS'(1);
    if (byte_fire) begin
      if (is_run) begin
        pixel_index_nxt = run_done ? '0 : pixel_index_r + INDEX_BITS'(run_len);
      end
      case (phase_r)
        PH_VALUE: begin
          phase_nxt = PH_HEADER;
        end
        PH_LITERAL: begin
          literal_left_nxt = run_done ? '0 : literal_dec;
          if (run_done || (literal_dec == '0)) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          if (code_byte == HDR_NOP) begin
            phase_nxt = PH_HEADER;
          end else if (!code_byte[BYTE_BITS-1]) begin
            literal_left_nxt = code_byte + BYTE_BITS'(1);
            phase_nxt        = PH_LITERAL;
          end else begin
            // 257 - b, for b in 129..255
            repeat_length_nxt = (LENGTH_BITS + 1)'(257) - (LENGTH_BITS + 1)'(code_byte);
            phase_nxt         = PH_VALUE;
          end
        end
      endcase
    end
  end

  // Hold decode state and the plane size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_pixels_r  <= CFG_BITS'(1);
      phase_r         <= PH_HEADER;
      literal_left_r  <= '0;
      repeat_length_r <= '0;
      pixel_index_r   <= '0;
    end else begin
      if (cfg.valid) begin
        plane_pixels_r <= cfg.data;
      end
      phase_r         <= phase_nxt;
      literal_left_r  <= literal_left_nxt;
      repeat_length_r <= repeat_length_nxt;
      pixel_index_r   <= pixel_index_nxt;
    end
  end

  // Form the run word for the queue
  assign run_push             = byte_fire && is_run;
  assign run_data.pixel_value = code_byte;
  assign run_data.run_start   = START_BITS'(pixel_index_r);
  assign run_data.run_length  = LENGTH_BITS'(run_len);
  assign run_data.plane_done  = run_done;

endmodule

@@ src/pbd_queue.sv @@
// Short queue of decoded runs between front and back.
module pbd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pbd_pkg::pbd_run_t push_data,
  output logic              has_room,
  input  logic              pop,
  output logic              not_empty,
  output pbd_pkg::pbd_run_t pop_data
);
  import pbd_pkg::*;

  pbd_run_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;

  assign has_room  = (count_r < QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // Store a pushed run
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_BITS'(1);
      end
    end
  end

endmodule

@@ src/pbd_back.sv @@
// Back end: output register that presents runs to the result stream.
module pbd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              run_avail,
  input  pbd_pkg::pbd_run_t run_data,
  output logic              run_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pbd_pkg::pbd_run_t out_run
);
  import pbd_pkg::*;

  logic     valid_r;
  pbd_run_t run_r;

  // Load the next run when the register is free or being drained
  assign run_pop   = run_avail && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_run   = run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (run_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run_pop) begin
      run_r <= run_data;
    end
  end

endmodule

@@ src/packbits_plane_decoder.sv @@
// PackBits plane decoder top level: takes one coded byte per word and
// emits one run word per pixel value. Runs a sustained one input word per
// clock while the run queue has room; a header byte yields no result, a
// literal byte or a repeat value yields one run. The run of an accepted
// byte is written into the run queue and then moved into the output
// register. The input stalls only when the run queue is full because the
// output side is held. The plane size register resets to 1 and is to be
// written only while the block is idle, by the user; the block does not enforce it.
module packbits_plane_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: plane size in pixels
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  // Coded byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] code_byte
  // Decoded runs
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] pixel_value, [31:8] run_start, [39:32] run_length
  output logic        out_tlast   // plane_done
);
  import pbd_pkg::*;

  pbd_cfg_t cfg;
  logic     byte_fire;
  logic     run_push, q_room, q_avail, q_pop;
  pbd_run_t run_in, run_q, run_out;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.data  = cfg_data;

  assign in_tready = q_room;
  assign byte_fire = in_tvalid && in_tready;

  pbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .byte_fire (byte_fire),
    .code_byte (in_tdata),
    .run_push  (run_push),
    .run_data  (run_in)
  );

  pbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (run_push),
    .push_data (run_in),
    .has_room  (q_room),
    .pop       (q_pop),
    .not_empty (q_avail),
    .pop_data  (run_q)
  );

  pbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_avail (q_avail),
    .run_data  (run_q),
    .run_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_run   (run_out)
  );

  // Pack the run word
  assign out_tdata = {run_out.run_length, run_out.run_start, run_out.pixel_value};
  assign out_tlast = run_out.plane_done;

endmodule

@@ src/pbd_checker.sv @@
// Port-level checks of the PackBits plane decoder, bound to the top level.
module pbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // A held result word keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // A run always covers at least one pixel
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:32] != 8'd0)
    else $error("zero-length run");

  // A run never exceeds 128 pixels
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39] |-> out_tdata[38:32] == 7'd0)
    else $error("run longer than 128 pixels");

  // Reset empties the result side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind packbits_plane_decoder pbd_checker u_pbd_checker (.*);

@@ tb/plane_run_scoreboard_pkg.sv @@
// Scoreboard class that predicts decoded PackBits runs and checks them.
`timescale 1ns / 1ps
package plane_run_scoreboard_pkg;
  import pbd_pkg::*;

  // Offset that turns a repeat header byte into its run length
  localparam int unsigned REPEAT_BIAS = 257;

  class plane_run_scoreboard;
    typedef enum logic [1:0] {
      EXPECT_HEADER,
      EXPECT_VALUE,
      IN_LITERAL
    } decode_phase_e;

    decode_phase_e         phase;
    logic [7:0]            literal_left;
    logic [7:0]            repeat_length;
    logic [INDEX_BITS-1:0] pixel_index;
    logic [CFG_BITS-1:0]   plane_pixels;
    pbd_run_t              expected_runs[$];
    int unsigned           mismatches;

    function new();
      phase         = EXPECT_HEADER;
      literal_left  = '0;
      repeat_length = '0;
      pixel_index   = '0;
      plane_pixels  = CFG_BITS'(1);
      mismatches    = 0;
    endfunction

    function void set_plane_pixels(logic [CFG_BITS-1:0] pixels);
      plane_pixels = pixels;
    endfunction

    // Queue the run of one pixel value; return 1 when it fills the plane
    function bit queue_run(logic [BYTE_BITS-1:0] value, int unsigned want);
      pbd_run_t        run;
      longint unsigned plane_size;
      longint unsigned pixels_left;
      longint unsigned run_len;
      plane_size  = plane_pixels & ((64'd1 << INDEX_BITS) - 64'd1);
      // an index already past the plane end closes the plane with one pixel
      pixels_left = (pixel_index < plane_size) ? plane_size - pixel_index : 1;
      run_len     = (want < pixels_left) ? want : pixels_left;
      run.pixel_value = value;
      run.run_start   = START_BITS'(pixel_index);
      run.run_length  = LENGTH_BITS'(run_len);
      run.plane_done  = (run_len == pixels_left);
      expected_runs.push_back(run);
      if (run.plane_done) begin
        pixel_index = '0;
      end else begin
        pixel_index = INDEX_BITS'(pixel_index + run_len);
      end
      return run.plane_done;
    endfunction

    // Advance the decoder state by one accepted byte
    function void note_byte(logic [BYTE_BITS-1:0] code);
      bit filled;
      case (phase)
        EXPECT_VALUE: begin
          void'(queue_run(code, repeat_length));
          phase = EXPECT_HEADER;
        end
        IN_LITERAL: begin
          filled       = queue_run(code, 1);
          literal_left = literal_left - 8'd1;
          // a full plane drops the literal bytes still owed
          if (filled) begin
            literal_left = '0;
            phase        = EXPECT_HEADER;
          end else if (literal_left == 8'd0) begin
            phase = EXPECT_HEADER;
          end
        end
        default: begin
          phase = EXPECT_HEADER;
          if (code != HDR_NOP) begin
            if (code < HDR_NOP) begin
              literal_left = code + 8'd1;
              phase        = IN_LITERAL;
            end else begin
              repeat_length = 8'(REPEAT_BIAS - code);
              phase         = EXPECT_VALUE;
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one output word with the oldest expected run
    task check_run(pbd_run_t got);
      pbd_run_t want;
      if (expected_runs.size() == 0) begin
        report($sformatf("unexpected run value %0d start %0d length %0d done %0b",
                         got.pixel_value, got.run_start, got.run_length, got.plane_done));
        return;
      end
      want = expected_runs.pop_front();
      if (got.pixel_value !== want.pixel_value)
        report($sformatf("pixel_value %0d, want %0d", got.pixel_value, want.pixel_value));
      if (got.run_start !== want.run_start)
        report($sformatf("run_start %0d, want %0d", got.run_start, want.run_start));
      if (got.run_length !== want.run_length)
        report($sformatf("run_length %0d, want %0d", got.run_length, want.run_length));
      if (got.plane_done !== want.plane_done)
        report($sformatf("plane_done %0b, want %0b", got.plane_done, want.plane_done));
    endtask
  endclass

endpackage

@@ tb/packbits_plane_decoder_tb.sv @@
// Testbench top: drives coded bytes and plane sizes into the decoder, checks every run.
`timescale 1ns / 1ps
module packbits_plane_decoder_tb;
  import pbd_pkg::*;
  import plane_run_scoreboard_pkg::*;

  localparam logic [CFG_BITS-1:0] PLANE_MAX     = {CFG_BITS{1'b1}};
  localparam int unsigned         SETTLE_CYCLES = 4;
  localparam int unsigned         HOLD_CYCLES   = 80;
  localparam int unsigned         PHASE_ITEMS   = 200;
  localparam int unsigned         RANDOM_PHASES = 8;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] code_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;   // [7:0] pixel_value, [31:8] run_start, [39:32] run_length
  logic        out_tlast;   // plane_done

  plane_run_scoreboard sb;
  int unsigned         items_sent = 0;
  bit                  no_gaps = 1'b0;
  bit                  hold_request = 1'b0;

  packbits_plane_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Gap length: mostly none, often short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offer one byte and hold it until the word is taken
  task automatic send_byte(input logic [BYTE_BITS-1:0] code);
    int unsigned gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(code);
    if (code != HDR_NOP) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_literal_header(input int unsigned count);
    send_byte(BYTE_BITS'(count - 1));
  endtask

  task automatic send_repeat_header(input int unsigned count);
    send_byte(BYTE_BITS'(REPEAT_BIAS - count));
  endtask

  // Drop valid, drain all expected runs, then let the front stage empty
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_runs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_plane(input logic [CFG_BITS-1:0] pixels);
    cfg_valid <= 1'b1;
    cfg_data  <= pixels;
    do @(posedge clk); while (!cfg_ready);
    sb.set_plane_pixels(pixels);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed runs with random content, some skips and stray bytes
  task automatic random_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned count;
    int unsigned k;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        count = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 16) : $urandom_range(17, 128);
        send_literal_header(count);
        for (k = 0; k < count; k++) send_byte(BYTE_BITS'($urandom));
      end else if (pick < 90) begin
        send_repeat_header($urandom_range(2, 128));
        send_byte(BYTE_BITS'($urandom));
      end else if (pick < 94) begin
        send_byte(HDR_NOP);
      end else begin
        send_byte(BYTE_BITS'($urandom));
      end
    end
  endtask

  // Check each output word as it is taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_run(pbd_run_t'({out_tlast, out_tdata}));
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = 0;
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;
      end else if (!no_gaps) begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned           i;
    logic [CFG_BITS-1:0]   pixels;
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // One-pixel plane from reset: every run clips to one pixel and closes the plane
    send_literal_header(1);
    send_byte(8'h00);
    send_repeat_header(128);
    send_byte(8'hFF);
    send_byte(HDR_NOP);
    // plane fills on the first literal byte, the next byte is a header
    send_literal_header(3);
    send_byte(8'h11);
    send_repeat_header(3);
    send_byte(8'h22);
    wait_idle();

    // Largest plane: runs advance the index without closing
    write_plane(PLANE_MAX);
    send_repeat_header(2);
    send_byte(8'h55);
    send_repeat_header(128);
    send_byte(8'hAA);
    send_byte(HDR_NOP);
    send_literal_header(2);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();

    // Shrink the plane below the current index, then clip a long repeat
    write_plane(CFG_BITS'(5));
    send_repeat_header(2);
    send_byte(8'h33);
    send_repeat_header(128);
    send_byte(8'h44);
    send_literal_header(1);
    send_byte(8'h7E);
    wait_idle();

    // Random phases across plane sizes
    for (i = 0; i < RANDOM_PHASES; i++) begin
      case (i)
        0: pixels = CFG_BITS'(1);
        1: pixels = CFG_BITS'($urandom_range(2, 40));
        3: pixels = PLANE_MAX;
        4: pixels = CFG_BITS'($urandom_range(2, 40));
        5: pixels = CFG_BITS'($urandom_range(3001, 16777214));
        7: pixels = CFG_BITS'($urandom_range(1, 300));
        default: pixels = CFG_BITS'($urandom_range(41, 3000));
      endcase
      write_plane(pixels);
      no_gaps = (i == 4);
      if (i == 2) hold_request = 1'b1;
      random_phase(PHASE_ITEMS);
      wait_idle();
    end
    no_gaps = 1'b0;

    repeat (10) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
